>>> hdl/hffa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hffa_pkg
// Shared constants for the hinted first-free slot allocator.
// ----------------------------------------------------------------------------
package hffa_pkg;

	localparam int SLOT_W    = 8;                 // slot number width
	localparam int MAX_SLOTS = 255;               // highest slot kept in the bitmap
	localparam int WORD_W    = 32;                // bits per bitmap memory word
	localparam int BIT_W     = $clog2(WORD_W);    // bit index inside a word
	localparam int WORD_CNT  = (1 << SLOT_W) / WORD_W;
	localparam int WADDR_W   = $clog2(WORD_CNT);

	localparam logic [SLOT_W-1:0] SLOT_COUNT_RESET = SLOT_W'(255);
	localparam logic [SLOT_W-1:0] MAX_SLOT_VAL     = SLOT_W'(MAX_SLOTS);

endpackage

>>> hdl/hffa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hffa_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hffa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/hinted_first_free_allocator_core.sv
`timescale 1ns / 1ps
// flow: the preferred slot's bitmap word is read first; if that slot is taken,
//   the first-fit scan reads the words from word 0 up, at most all eight
// throughput: one request at a time; the scan reads one 32-bit word per cycle
//   from the single read port of the bitmap memory
// reset: slot_count returns to 255, per-word valid flags clear so every slot
//   reads as free at once, no clearing pass
// ----------------------------------------------------------------------------
// hinted_first_free_allocator_core
// Bitmap slot allocator over slots 1 to slot_count: grants the preferred
// slot when free, else the lowest free slot, and marks the granted slot as used.
// ----------------------------------------------------------------------------
module hinted_first_free_allocator_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [hffa_pkg::SLOT_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [hffa_pkg::SLOT_W-1:0] preferred_slot,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       granted,
	output logic [hffa_pkg::SLOT_W-1:0] slot_number
);
	import hffa_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HINT = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]          state_q, state_d;
	logic [SLOT_W-1:0]   slot_count_q;
	logic [SLOT_W-1:0]   want_q;
	logic [SLOT_W-1:0]   limit_q;
	logic [WADDR_W-1:0]  rd_addr_s1;
	logic [WORD_CNT-1:0] word_valid_q;
	logic                res_grant_q, res_grant_d;
	logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
	logic                out_valid_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic                out_grant_q;

	logic                ram_we, ram_re;
	logic [WADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [WORD_W-1:0]   ram_wdata, ram_rdata;

	logic [WORD_W-1:0]   cur_word, scan_mask, masked;
	logic [BIT_W-1:0]    low_pos;
	logic                hint_free;
	logic                in_acc;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign granted     = out_grant_q;
	assign slot_number = out_slot_q;

	hffa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(WORD_CNT)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// a word never written reads as all free while its valid flag is clear
	assign cur_word = word_valid_q[rd_addr_s1] ? ram_rdata : '1;

	always_comb begin
		for (int b = 0; b < WORD_W; b++) begin
			logic [SLOT_W-1:0] s;
			s = {rd_addr_s1, BIT_W'(b)};
			scan_mask[b] = (s != '0) && (s <= limit_q);
		end
	end

	assign masked    = cur_word & scan_mask;
	assign hint_free = (want_q != '0) && (want_q <= limit_q) && cur_word[want_q[BIT_W-1:0]];

	// priority encoder, lowest set bit wins
	always_comb begin
		low_pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (masked[i]) begin
				low_pos = BIT_W'(i);
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		ram_we      = 1'b0;
		ram_waddr   = rd_addr_s1;
		ram_wdata   = cur_word;
		ram_re      = 1'b0;
		ram_raddr   = '0;
		res_grant_d = res_grant_q;
		res_slot_d  = res_slot_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					ram_re    = 1'b1;
					ram_raddr = preferred_slot[SLOT_W-1:BIT_W];
					state_d   = ST_HINT;
				end
			end
			ST_HINT: begin
				if (hint_free) begin
					ram_we      = 1'b1;
					ram_wdata   = cur_word & ~(WORD_W'(1) << want_q[BIT_W-1:0]);
					res_grant_d = 1'b1;
					res_slot_d  = want_q;
					state_d     = ST_DONE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = '0;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (masked != '0) begin
					ram_we      = 1'b1;
					ram_wdata   = cur_word & ~(WORD_W'(1) << low_pos);
					res_grant_d = 1'b1;
					res_slot_d  = {rd_addr_s1, low_pos};
					state_d     = ST_DONE;
				end else if (rd_addr_s1 == WADDR_W'(WORD_CNT - 1)) begin
					res_grant_d = 1'b0;
					res_slot_d  = '0;
					state_d     = ST_DONE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = rd_addr_s1 + WADDR_W'(1);
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_count_q <= SLOT_COUNT_RESET;
			word_valid_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				slot_count_q <= cfg_data;
			end
			if (ram_we) begin
				word_valid_q[ram_waddr] <= 1'b1;
			end
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_grant_q <= res_grant_d;
		res_slot_q  <= res_slot_d;
		if (ram_re) begin
			rd_addr_s1 <= ram_raddr;
		end
		if (in_acc) begin
			want_q  <= preferred_slot;
			limit_q <= (slot_count_q > MAX_SLOT_VAL) ? MAX_SLOT_VAL : slot_count_q;
		end
		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			out_grant_q <= res_grant_q;
			out_slot_q  <= res_slot_q;
		end
	end

endmodule

>>> hdl/hffa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hffa_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module hffa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        granted,
	input logic [hffa_pkg::SLOT_W-1:0] slot_number
);
	import hffa_pkg::*;

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted) && $stable(slot_number))
		else $error("stalled result changed");

	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> slot_number == '0)
		else $error("slot number not zero without grant");

	a_grant_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted |-> slot_number != '0)
		else $error("slot zero granted");

	// one request in flight: busy right after an accepted transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");

endmodule

bind hinted_first_free_allocator_core hffa_checker u_hffa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.granted    (granted),
	.slot_number(slot_number)
);
